@@ rtl/kmd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types and constants for the key matrix debounce event block.
// ----------------------------------------------------------------------------
package kmd_pkg;

	localparam int NIBBLE_ROWS = 4;
	localparam int COL_W       = 2;
	localparam int BYTE_W      = 8;
	localparam int TIME_W      = 32;
	localparam int DEB_W       = 16;
	localparam int NOTE_W      = 7;
	localparam int KEY_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_NIBBLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTE_BASE  = 2'd2;

	localparam logic [DEB_W-1:0]  DEBOUNCE_RESET  = 16'd50;
	localparam logic [NOTE_W-1:0] NOTE_BASE_RESET = 7'd60;
	localparam logic [NOTE_W:0]   NOTE_MAX        = 8'd127;

	typedef struct packed {
		logic              row_nibble_high;
		logic [DEB_W-1:0]  debounce_ms;
		logic [NOTE_W-1:0] note_base;
	} kmd_cfg_t;

	// one column read that changed at least one key
	typedef struct packed {
		logic [NIBBLE_ROWS-1:0] mask;
		logic [NIBBLE_ROWS-1:0] lvl;
		logic [COL_W-1:0]       col;
	} kmd_entry_t;

endpackage
`default_nettype wire

@@ rtl/kmd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_front
// Accepts column reads, debounces each scanned key and records changes.
// ----------------------------------------------------------------------------
module kmd_front #(
	parameter int ROWS = 4,
	parameter int COLS = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire kmd_pkg::kmd_cfg_t           cfg,
	input  wire logic                        push,
	input  wire logic [kmd_pkg::COL_W-1:0]   column,
	input  wire logic [kmd_pkg::BYTE_W-1:0]  row_byte,
	input  wire logic [kmd_pkg::TIME_W-1:0]  now_ms,
	input  wire logic                        q_full,
	output      logic                        enq,
	output      kmd_pkg::kmd_entry_t         enq_entry
);
	import kmd_pkg::*;

	localparam int LIM   = (ROWS < NIBBLE_ROWS) ? ROWS : NIBBLE_ROWS;
	localparam int CIX_W = (COLS > 1) ? $clog2(COLS) : 1;
	localparam logic [3:0] COLS_N = 4'(COLS);

	logic                   level_q [LIM][COLS];
	logic [TIME_W-1:0]      time_q  [LIM][COLS];
	logic [CIX_W-1:0]       cidx;
	logic                   col_ok;
	logic                   acc;
	logic [NIBBLE_ROWS-1:0] rows;
	logic [NIBBLE_ROWS-1:0] fire;
	logic [TIME_W-1:0]      diff [LIM];

	assign cidx   = CIX_W'(column);
	assign col_ok = ({2'b00, column} < COLS_N);
	assign acc    = push && !q_full;
	assign rows   = ~(cfg.row_nibble_high ? row_byte[7:4] : row_byte[3:0]);

	always_comb begin
		fire = '0;
		for (int r = 0; r < LIM; r++) begin
			diff[r] = now_ms - time_q[r][cidx];
			fire[r] = col_ok && (rows[r] != level_q[r][cidx])
				&& (diff[r] > {16'd0, cfg.debounce_ms});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < LIM; r++) begin
				for (int c = 0; c < COLS; c++) begin
					level_q[r][c] <= 1'b0;
					time_q[r][c]  <= '0;
				end
			end
		end else if (acc) begin
			for (int r = 0; r < LIM; r++) begin
				if (fire[r]) begin
					level_q[r][cidx] <= rows[r];
					time_q[r][cidx]  <= now_ms;
				end
			end
		end
	end

	assign enq            = acc && (fire != '0);
	assign enq_entry.mask = fire;
	assign enq_entry.lvl  = rows;
	assign enq_entry.col  = column;

endmodule
`default_nettype wire

@@ rtl/kmd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_queue
// Short queue of changed column reads between front and back.
// ----------------------------------------------------------------------------
module kmd_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire kmd_pkg::kmd_entry_t wr_data,
	output      logic                full,
	input  wire logic                rd_en,
	output      kmd_pkg::kmd_entry_t rd_data,
	output      logic                empty
);
	import kmd_pkg::*;

	kmd_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/kmd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_back
// Splits each changed read into key events, one per cycle while popped, into a result register.
// ----------------------------------------------------------------------------
module kmd_back #(
	parameter int COLS = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [kmd_pkg::NOTE_W-1:0]  note_base,
	input  wire kmd_pkg::kmd_entry_t         q_data,
	input  wire logic                        q_empty,
	output      logic                        q_rd,
	input  wire logic                        pop,
	output      logic                        empty,
	output      logic [kmd_pkg::KEY_W-1:0]   key_index,
	output      logic                        is_pressed,
	output      logic [kmd_pkg::NOTE_W-1:0]  note_number,
	output      logic                        last
);
	import kmd_pkg::*;

	localparam logic [7:0] COLS_8 = 8'(COLS);

	logic [NIBBLE_ROWS-1:0] work_mask_q;
	logic [NIBBLE_ROWS-1:0] work_lvl_q;
	logic [COL_W-1:0]       work_col_q;
	logic                   out_vld_q;
	logic [KEY_W-1:0]       key_q;
	logic                   press_q;
	logic [NOTE_W-1:0]      note_q;
	logic                   last_q;

	logic [NIBBLE_ROWS-1:0] low_bit;
	logic [NIBBLE_ROWS-1:0] next_mask;
	logic [1:0]             row_sel;
	logic [7:0]             key;
	logic [7:0]             note_sum;
	logic                   out_free;
	logic                   adv;
	logic                   load_work;

	assign low_bit   = work_mask_q & (~work_mask_q + 1'b1);
	assign next_mask = work_mask_q & ~low_bit;
	assign out_free  = !out_vld_q || pop;
	assign adv       = out_free && (work_mask_q != '0);
	assign load_work = (work_mask_q == '0) || (adv && (next_mask == '0));
	assign q_rd      = load_work && !q_empty;

	always_comb begin
		row_sel = 2'd0;
		for (int r = NIBBLE_ROWS - 1; r >= 0; r--) begin
			if (work_mask_q[r]) begin
				row_sel = 2'(r);
			end
		end
	end

	assign key      = ({6'd0, row_sel} * COLS_8) + {6'd0, work_col_q};
	assign note_sum = {1'b0, note_base} + key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_mask_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (q_rd) begin
				work_mask_q <= q_data.mask;
			end else if (adv) begin
				work_mask_q <= next_mask;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			work_col_q <= q_data.col;
			work_lvl_q <= q_data.lvl;
		end
		if (adv) begin
			key_q   <= key[KEY_W-1:0];
			press_q <= work_lvl_q[row_sel];
			note_q  <= (note_sum > NOTE_MAX) ? NOTE_MAX[NOTE_W-1:0] : note_sum[NOTE_W-1:0];
			last_q  <= (next_mask == '0);
		end
	end

	assign empty       = !out_vld_q;
	assign key_index   = key_q;
	assign is_pressed  = press_q;
	assign note_number = note_q;
	assign last        = last_q;

endmodule
`default_nettype wire

@@ rtl/keypad_matrix_debounce_events.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_matrix_debounce_events
// Debounced key matrix scanner that turns column reads into key events.
// ----------------------------------------------------------------------------
// Each pushed request is one column read; every debounced change of a key in
// that column becomes one event, lowest row first, the final one with last set.
// A request is taken every cycle while the internal four-entry queue has room;
// a read that changes n keys gives n events, so the one-event-per-cycle result
// register, while its events are popped, sets the sustained rate. A read passes
// from the queue into the work register and its first event then into the result
// register. Per-key state is cleared by reset, no clearing pass is needed.
module keypad_matrix_debounce_events #(
	parameter int ROWS = 4,
	parameter int COLS = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [kmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kmd_pkg::DEB_W-1:0]      cfg_wdata,
	input  wire logic                           push,
	output      logic                           full,
	input  wire logic [kmd_pkg::COL_W-1:0]      column,
	input  wire logic [kmd_pkg::BYTE_W-1:0]     row_byte,
	input  wire logic [kmd_pkg::TIME_W-1:0]     now_ms,
	output      logic                           empty,
	input  wire logic                           pop,
	output      logic [kmd_pkg::KEY_W-1:0]      key_index,
	output      logic                           is_pressed,
	output      logic [kmd_pkg::NOTE_W-1:0]     note_number,
	output      logic                           last
);
	import kmd_pkg::*;

	kmd_cfg_t   cfg_q;
	logic       q_full;
	logic       q_empty;
	logic       q_rd;
	logic       enq;
	kmd_entry_t enq_entry;
	kmd_entry_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_nibble_high <= 1'b0;
			cfg_q.debounce_ms     <= DEBOUNCE_RESET;
			cfg_q.note_base       <= NOTE_BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW_NIBBLE: cfg_q.row_nibble_high <= cfg_wdata[0];
				CFG_DEBOUNCE:   cfg_q.debounce_ms     <= cfg_wdata;
				CFG_NOTE_BASE:  cfg_q.note_base       <= cfg_wdata[NOTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign full = q_full;

	kmd_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.column    (column),
		.row_byte  (row_byte),
		.now_ms    (now_ms),
		.q_full    (q_full),
		.enq       (enq),
		.enq_entry (enq_entry)
	);

	kmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (enq),
		.wr_data (enq_entry),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	kmd_back #(.COLS(COLS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.note_base   (cfg_q.note_base),
		.q_data      (q_data),
		.q_empty     (q_empty),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.key_index   (key_index),
		.is_pressed  (is_pressed),
		.note_number (note_number),
		.last        (last)
	);

endmodule
`default_nettype wire

@@ rtl/kmd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_checker
// Port-level checks of the event stream, bound to the top level.
// ----------------------------------------------------------------------------
module kmd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [3:0] key_index,
	input wire logic       is_pressed,
	input wire logic [6:0] note_number,
	input wire logic       last
);

	// more events of the same read follow without a gap
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last |=> !empty)
		else $error("event run broken before last");

	// events of one read come in rising row order
	a_note_order: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last |=> note_number >= $past(note_number))
		else $error("events of one read out of order");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(key_index) && $stable(is_pressed)
			&& $stable(note_number) && $stable(last))
		else $error("stalled event changed");

endmodule

bind keypad_matrix_debounce_events kmd_checker u_kmd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.key_index   (key_index),
	.is_pressed  (is_pressed),
	.note_number (note_number),
	.last        (last)
);
`default_nettype wire
